// ===== rtl/gpars_pkg.sv =====
`default_nettype none

package gpars_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW  = 2;
  localparam logic [CfgIdxW-1:0] CFG_ROWS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_COLS = 2'd1;

  localparam int unsigned CfgDataW = 7;
  localparam logic [CfgDataW-1:0] CFG_RESET = 7'd64;

  // result of one item, handed from the sequencer to the output register
  typedef struct packed {
    logic [31:0] rect_sum;
    logic        index_error;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/gpars_mem.sv =====
`default_nettype none

module gpars_mem #(
  parameter int unsigned AW    = 12,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [31:0]   wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [31:0]   rdata_o
);

  logic [31:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/gpars_ctrl.sv =====
`default_nettype none

module gpars_ctrl #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64,
  parameter int unsigned AW       = 12
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [6:0]            rows_in_use_i,
  input  wire logic [6:0]            cols_in_use_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [1:0]            op_i,
  input  wire logic [6:0]            row_a_i,
  input  wire logic [6:0]            col_a_i,
  input  wire logic [6:0]            row_b_i,
  input  wire logic [6:0]            col_b_i,
  input  wire logic signed [31:0]    add_value_i,
  output logic                       res_valid_o,
  input  wire logic                  res_ready_i,
  output gpars_pkg::res_t            res_o,
  output logic                       mem_we_o,
  output logic [AW-1:0]              mem_waddr_o,
  output logic [31:0]                mem_wdata_o,
  output logic [AW-1:0]              mem_raddr_o,
  input  wire logic [31:0]           mem_rdata_i
);

  import gpars_pkg::*;

  localparam int unsigned RW    = $clog2(MAX_ROWS);
  localparam int unsigned CW    = $clog2(MAX_COLS);
  localparam int unsigned RCW   = RW + 2;
  localparam int unsigned CCW   = CW + 2;
  localparam int unsigned DEPTH = MAX_ROWS * (2 ** CW);

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_SUM   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_UPD_RD,
    S_UPD_WR,
    S_SUM,
    S_FIN
  } state_e;

  state_e         state_q;
  logic [AW-1:0]  clr_addr_q;
  logic           clr_res_q;
  logic [RCW-1:0] i_q, rlo_q, rhi_q;
  logic [CCW-1:0] j_q, c0_q, clo_q, chi_q;
  logic [1:0]     k_q;
  logic [31:0]    val_q;
  logic [31:0]    acc_q;
  logic           err_q;
  logic           pend_q;
  logic           pend_neg_q;

  logic [RCW-1:0] nr, i_lsb, i_up, i_dn, ra, rb;
  logic [CCW-1:0] nc, j_lsb, j_up, j_dn, ca, cb;
  logic [AW-1:0]  cur_addr;
  logic [1:0]     k_nx;
  logic           accept;
  logic           add_bad, sum_bad;

  // register value of zero acts as one, above the maximum as the maximum
  always_comb begin
    if (rows_in_use_i == 7'd0) begin
      nr = RCW'(1);
    end else if (32'(rows_in_use_i) > 32'(MAX_ROWS)) begin
      nr = RCW'(MAX_ROWS);
    end else begin
      nr = RCW'(rows_in_use_i);
    end
    if (cols_in_use_i == 7'd0) begin
      nc = CCW'(1);
    end else if (32'(cols_in_use_i) > 32'(MAX_COLS)) begin
      nc = CCW'(MAX_COLS);
    end else begin
      nc = CCW'(cols_in_use_i);
    end
  end

  assign add_bad = (row_a_i == 7'd0) || (32'(row_a_i) > 32'(nr))
                || (col_a_i == 7'd0) || (32'(col_a_i) > 32'(nc));
  assign sum_bad = (row_a_i == 7'd0) || (col_a_i == 7'd0)
                || (32'(row_b_i) > 32'(nr)) || (32'(col_b_i) > 32'(nc))
                || (row_a_i > row_b_i) || (col_a_i > col_b_i);

  // only used once the range checks passed, so they fit
  assign ra = RCW'(row_a_i);
  assign rb = RCW'(row_b_i);
  assign ca = CCW'(col_a_i);
  assign cb = CCW'(col_b_i);

  assign i_lsb = i_q & (~i_q + RCW'(1));
  assign j_lsb = j_q & (~j_q + CCW'(1));
  assign i_up  = i_q + i_lsb;
  assign j_up  = j_q + j_lsb;
  assign i_dn  = i_q - i_lsb;
  assign j_dn  = j_q - j_lsb;
  assign k_nx  = k_q + 2'd1;

  assign cur_addr = {RW'(i_q - RCW'(1)), CW'(j_q - CCW'(1))};

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  assign res_valid_o       = (state_q == S_FIN);
  assign res_o.rect_sum    = acc_q;
  assign res_o.index_error = err_q;

  assign mem_raddr_o = cur_addr;
  assign mem_we_o    = (state_q == S_CLR) || (state_q == S_UPD_WR);
  assign mem_waddr_o = (state_q == S_CLR) ? clr_addr_q : cur_addr;
  assign mem_wdata_o = (state_q == S_CLR) ? 32'd0 : mem_rdata_i + val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLR;
      clr_addr_q <= '0;
      clr_res_q  <= 1'b0;
      pend_q     <= 1'b0;
      pend_neg_q <= 1'b0;
      i_q        <= '0;
      j_q        <= '0;
      c0_q       <= '0;
      rlo_q      <= '0;
      rhi_q      <= '0;
      clo_q      <= '0;
      chi_q      <= '0;
      k_q        <= '0;
      val_q      <= '0;
      acc_q      <= '0;
      err_q      <= 1'b0;
    end else begin
      pend_q <= 1'b0;
      // read issued last cycle lands now
      if (pend_q) begin
        acc_q <= pend_neg_q ? acc_q - mem_rdata_i : acc_q + mem_rdata_i;
      end

      unique case (state_q)
        S_CLR: begin
          if (clr_addr_q == AW'(DEPTH - 1)) begin
            state_q <= clr_res_q ? S_FIN : S_IDLE;
          end else begin
            clr_addr_q <= clr_addr_q + AW'(1);
          end
        end

        S_IDLE: begin
          if (accept) begin
            acc_q <= '0;
            err_q <= 1'b0;
            unique case (op_e'(op_i))
              OP_ADD: begin
                if (add_bad) begin
                  err_q   <= 1'b1;
                  state_q <= S_FIN;
                end else begin
                  i_q     <= ra;
                  j_q     <= ca;
                  c0_q    <= ca;
                  val_q   <= add_value_i;
                  state_q <= S_UPD_RD;
                end
              end
              OP_SUM: begin
                if (sum_bad) begin
                  err_q   <= 1'b1;
                  state_q <= S_FIN;
                end else begin
                  rlo_q   <= ra - RCW'(1);
                  clo_q   <= ca - CCW'(1);
                  rhi_q   <= rb;
                  chi_q   <= cb;
                  i_q     <= rb;
                  j_q     <= cb;
                  c0_q    <= cb;
                  k_q     <= 2'd0;
                  state_q <= S_SUM;
                end
              end
              OP_CLEAR: begin
                clr_addr_q <= '0;
                clr_res_q  <= 1'b1;
                state_q    <= S_CLR;
              end
              OP_NONE: begin
                err_q   <= 1'b1;
                state_q <= S_FIN;
              end
              default: begin
                err_q   <= 1'b1;
                state_q <= S_FIN;
              end
            endcase
          end
        end

        S_UPD_RD: begin
          state_q <= S_UPD_WR;
        end

        S_UPD_WR: begin
          if (j_up <= nc) begin
            j_q     <= j_up;
            state_q <= S_UPD_RD;
          end else if (i_up <= nr) begin
            i_q     <= i_up;
            j_q     <= c0_q;
            state_q <= S_UPD_RD;
          end else begin
            state_q <= S_FIN;
          end
        end

        S_SUM: begin
          // corners in order: (hi,hi) +, (lo,hi) -, (hi,lo) -, (lo,lo) +
          if ((i_q == '0) || (j_q == '0)) begin
            if (k_q == 2'd3) begin
              state_q <= S_FIN;
            end else begin
              k_q  <= k_nx;
              i_q  <= k_nx[0] ? rlo_q : rhi_q;
              j_q  <= k_nx[1] ? clo_q : chi_q;
              c0_q <= k_nx[1] ? clo_q : chi_q;
            end
          end else begin
            pend_q     <= 1'b1;
            pend_neg_q <= k_q[0] ^ k_q[1];
            if (j_dn != '0) begin
              j_q <= j_dn;
            end else begin
              i_q <= i_dn;
              j_q <= c0_q;
            end
          end
        end

        S_FIN: begin
          if (res_ready_i) begin
            clr_res_q <= 1'b0;
            state_q   <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/grid_point_add_rect_sum.sv =====
// Two-dimensional binary indexed tree over a grid of 32-bit words.
// Input channel (in_valid_i / in_stall_o): one item per op: point add,
// rectangle sum or clear. Output channel (out_valid_o / out_stall_i): one
// result item per input item, in order. Config channel (cfg_valid_i /
// cfg_ready_o) writes rows_in_use (index 0) and cols_in_use (index 1);
// write it only while the block is idle.
// Items are worked one at a time through a tree memory with one write port
// and a registered read port:
//   point add    : a read, then a write back, per touched tree entry,
//                  up to (log2 rows + 1) * (log2 cols + 1) entries.
//   rectangle sum: one read per cycle over four prefix walks, with a step
//                  between corners in which no read is issued.
//   clear        : zeroes MAX_ROWS * 2^ceil(log2 MAX_COLS) entries, one per cycle.
//   bad index    : no tree access; the result carries index_error.
// After reset the same clearing pass runs (4096 entries at the default size)
// with in_stall_o high. Results sit in an output register; a stalled
// receiver holds it, and the next item is accepted meanwhile, its result
// waiting until the register frees up.
`default_nettype none

module grid_point_add_rect_sum #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [1:0]                        op_i,
  input  wire logic [6:0]                        row_a_i,
  input  wire logic [6:0]                        col_a_i,
  input  wire logic [6:0]                        row_b_i,
  input  wire logic [6:0]                        col_b_i,
  input  wire logic signed [31:0]                add_value_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [31:0]                     rect_sum_o,
  output logic                                   index_error_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [gpars_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [gpars_pkg::CfgDataW-1:0]    cfg_data_i
);

  import gpars_pkg::*;

  localparam int unsigned RW    = $clog2(MAX_ROWS);
  localparam int unsigned CW    = $clog2(MAX_COLS);
  localparam int unsigned AW    = RW + CW;
  localparam int unsigned DEPTH = MAX_ROWS * (2 ** CW);

  logic [CfgDataW-1:0] rows_q, cols_q;
  logic                out_valid_q;
  logic [31:0]         rect_sum_q;
  logic                index_error_q;

  logic          res_valid, res_ready;
  res_t          res;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_wdata, mem_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= CFG_RESET;
      cols_q <= CFG_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_ROWS) begin
        rows_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_COLS) begin
        cols_q <= cfg_data_i;
      end
    end
  end

  gpars_ctrl #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .AW       (AW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rows_in_use_i (rows_q),
    .cols_in_use_i (cols_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .row_a_i       (row_a_i),
    .col_a_i       (col_a_i),
    .row_b_i       (row_b_i),
    .col_b_i       (col_b_i),
    .add_value_i   (add_value_i),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata)
  );

  gpars_mem #(
    .AW    (AW),
    .DEPTH (DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output register: loads when empty or being drained this cycle
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      rect_sum_q    <= res.rect_sum;
      index_error_q <= res.index_error;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign rect_sum_o    = rect_sum_q;
  assign index_error_o = index_error_q;

endmodule

`default_nettype wire

// ===== tb/sv/grid_point_add_rect_sum_tb.sv =====
`default_nettype none

module grid_point_add_rect_sum_tb;
  import gpars_pkg::*;

  localparam int unsigned GRID_ROWS = 64;
  localparam int unsigned GRID_COLS = 64;
  localparam int unsigned PHASE_ITEMS = 210;
  localparam int unsigned NUM_PHASES = 9;
  localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 2'd3;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_RECT  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_SPARE = 2'd3
  } grid_op_e;

  // Mirror of the tree contents and bounds; queues one result per accepted item.
  class fenwick_mirror;
    bit [31:0] cells [GRID_ROWS*GRID_COLS];
    bit [6:0]  rows_reg;
    bit [6:0]  cols_reg;
    res_t      pending_sums[$];
    int        mismatches;

    function new();
      clear_cells();
      rows_reg = CFG_RESET;
      cols_reg = CFG_RESET;
      mismatches = 0;
    endfunction

    function void clear_cells();
      foreach (cells[k]) cells[k] = '0;
    endfunction

    function int unsigned clamp_dim(bit [6:0] v, int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
    endfunction

    function int unsigned rows_eff();
      return clamp_dim(rows_reg, GRID_ROWS);
    endfunction

    function int unsigned cols_eff();
      return clamp_dim(cols_reg, GRID_COLS);
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_ROWS: rows_reg = data;
        CFG_COLS: cols_reg = data;
        default: ;
      endcase
    endfunction

    function bit [31:0] prefix(int unsigned r, int unsigned c);
      bit [31:0] s;
      int unsigned i, j;
      s = '0;
      for (i = r; i > 0; i -= i & (~i + 1))
        for (j = c; j > 0; j -= j & (~j + 1))
          s += cells[(i - 1) * GRID_COLS + (j - 1)];
      return s;
    endfunction

    function void note_accepted(grid_op_e op, bit [6:0] ra, bit [6:0] ca,
                                bit [6:0] rb, bit [6:0] cb, bit [31:0] v);
      res_t r;
      int unsigned nr, nc, i, j, ra_u, ca_u, rb_u, cb_u;
      r = '0;
      nr = rows_eff();
      nc = cols_eff();
      ra_u = ra;
      ca_u = ca;
      rb_u = rb;
      cb_u = cb;
      case (op)
        OP_ADD: begin
          if (ra_u == 0 || ra_u > nr || ca_u == 0 || ca_u > nc) begin
            r.index_error = 1'b1;
          end else begin
            for (i = ra_u; i <= nr; i += i & (~i + 1))
              for (j = ca_u; j <= nc; j += j & (~j + 1))
                cells[(i - 1) * GRID_COLS + (j - 1)] += v;
          end
        end
        OP_RECT: begin
          if (ra_u == 0 || ca_u == 0 || rb_u > nr || cb_u > nc ||
              ra_u > rb_u || ca_u > cb_u) begin
            r.index_error = 1'b1;
          end else begin
            r.rect_sum = prefix(rb_u, cb_u) - prefix(ra_u - 1, cb_u)
                       - prefix(rb_u, ca_u - 1) + prefix(ra_u - 1, ca_u - 1);
          end
        end
        OP_CLEAR: clear_cells();
        default: r.index_error = 1'b1;
      endcase
      pending_sums.push_back(r);
    endfunction

    function void check_result(logic [31:0] sum, logic err);
      res_t want;
      if (pending_sums.size() == 0) begin
        $error("unexpected result item: rect_sum=%0d index_error=%0b", $signed(sum), err);
        mismatches++;
        return;
      end
      want = pending_sums.pop_front();
      if (sum !== want.rect_sum) begin
        $error("rect_sum mismatch: expected %0d, actual %0d",
               $signed(want.rect_sum), $signed(sum));
        mismatches++;
      end
      if (err !== want.index_error) begin
        $error("index_error mismatch: expected %0b, actual %0b", want.index_error, err);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [1:0]          op_i = '0;
  logic [6:0]          row_a_i = '0;
  logic [6:0]          col_a_i = '0;
  logic [6:0]          row_b_i = '0;
  logic [6:0]          col_b_i = '0;
  logic signed [31:0]  add_value_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic signed [31:0]  rect_sum_o;
  logic                index_error_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  fenwick_mirror board = new();
  bit                  calm = 1'b0;
  int unsigned         hold_left = 0;

  bit [6:0] phase_rows [NUM_PHASES] = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd5, 7'd64, 7'd2,
                                        7'd64, 7'd19};
  bit [6:0] phase_cols [NUM_PHASES] = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd37, 7'd3, 7'd64,
                                        7'd64, 7'd50};

  grid_point_add_rect_sum #(
    .MAX_ROWS(GRID_ROWS),
    .MAX_COLS(GRID_COLS)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .row_a_i       (row_a_i),
    .col_a_i       (col_a_i),
    .row_b_i       (row_b_i),
    .col_b_i       (col_b_i),
    .add_value_i   (add_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .rect_sum_o    (rect_sum_o),
    .index_error_o (index_error_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // result side: check each accepted item, then plan the next stall stretch
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_result(rect_sum_o, index_error_o);
      hold_left = calm ? 0 : $urandom_range(0, 5);
    end else if (hold_left > 0) begin
      hold_left--;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= (hold_left > 0);
  end

  task automatic send_item(grid_op_e op, bit [6:0] ra, bit [6:0] ca,
                           bit [6:0] rb, bit [6:0] cb, bit [31:0] v);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    op_i        <= op;
    row_a_i     <= ra;
    col_a_i     <= ca;
    row_b_i     <= rb;
    col_b_i     <= cb;
    add_value_i <= v;
    do @(posedge clk_i); while (in_stall_o);
    board.note_accepted(op, ra, ca, rb, cb, v);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.pending_sums.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_item();
    int unsigned nr, nc, kind;
    bit [6:0]    ra, ca, rb, cb;
    bit [31:0]   v;
    grid_op_e    op;
    nr = board.rows_eff();
    nc = board.cols_eff();
    ra = 7'($urandom_range(1, nr));
    ca = 7'($urandom_range(1, nc));
    rb = 7'($urandom_range(0, 127));
    cb = 7'($urandom_range(0, 127));
    v = $urandom;
    case ($urandom_range(0, 19))
      0: v = 32'h7fff_ffff;
      1: v = 32'h8000_0000;
      2: v = $urandom_range(0, 15) - 8;
      default: ;
    endcase
    kind = $urandom_range(0, 999);
    if (kind < 3) begin
      op = OP_CLEAR;
    end else if (kind < 430) begin
      op = OP_ADD;
    end else if (kind < 850) begin
      op = OP_RECT;
      rb = 7'($urandom_range(1, nr));
      ra = 7'($urandom_range(1, rb));
      cb = 7'($urandom_range(1, nc));
      ca = 7'($urandom_range(1, cb));
    end else begin
      // malformed items, plus rectangles with random bounds that may be valid
      case ($urandom_range(0, 5))
        0: op = OP_SPARE;
        1: begin
          op = OP_ADD;
          if ($urandom_range(0, 1)) ra = 0; else ca = 0;
        end
        2: begin
          op = OP_ADD;
          if ($urandom_range(0, 1)) ra = 7'($urandom_range(nr + 1, 127));
          else ca = 7'($urandom_range(nc + 1, 127));
        end
        3: begin
          op = OP_RECT;
          cb = 7'($urandom_range(1, nc));
          ca = 7'($urandom_range(1, cb));
          if (nr >= 2) begin
            rb = 7'($urandom_range(1, nr - 1));
            ra = 7'($urandom_range(rb + 1, nr));
          end else begin
            ra = 0;
          end
        end
        4: begin
          op = OP_RECT;
          rb = 7'($urandom_range(1, nr));
          ra = 7'($urandom_range(1, rb));
          if (nc >= 2) begin
            cb = 7'($urandom_range(1, nc - 1));
            ca = 7'($urandom_range(cb + 1, nc));
          end else begin
            cb = 7'($urandom_range(nc + 1, 127));
          end
        end
        default: begin
          op = OP_RECT;
          ra = 7'($urandom_range(0, 127));
          ca = 7'($urandom_range(0, 127));
        end
      endcase
    end
    send_item(op, ra, ca, rb, cb, v);
  endtask

  initial begin
    int unsigned p, k;
    @(posedge rst_ni);
    write_reg(CFG_ROWS, phase_rows[0]);
    write_reg(CFG_COLS, phase_cols[0]);

    calm = 1'b1;
    send_item(OP_RECT, 1, 1, 64, 64, 32'h0);
    send_item(OP_ADD, 1, 1, 0, 0, 32'h7fff_ffff);
    send_item(OP_ADD, 64, 64, 127, 127, 32'h8000_0000);
    send_item(OP_ADD, 1, 64, 0, 0, 32'hffff_ffff);
    send_item(OP_ADD, 64, 1, 0, 0, 32'h1);
    calm = 1'b0;
    send_item(OP_ADD, 37, 21, 0, 0, 32'd12345);
    send_item(OP_RECT, 1, 1, 64, 64, 32'hffff_ffff);
    send_item(OP_RECT, 64, 64, 64, 64, 32'h0);
    send_item(OP_RECT, 1, 1, 1, 1, 32'h0);
    send_item(OP_RECT, 2, 2, 63, 63, 32'h0);
    send_item(OP_ADD, 0, 5, 0, 0, 32'd9);
    send_item(OP_ADD, 5, 0, 0, 0, 32'd9);
    send_item(OP_ADD, 65, 1, 0, 0, 32'd9);
    send_item(OP_ADD, 127, 127, 127, 127, 32'h55aa_55aa);
    send_item(OP_RECT, 10, 1, 5, 64, 32'h0);
    send_item(OP_RECT, 1, 40, 64, 39, 32'h0);
    send_item(OP_RECT, 1, 1, 65, 64, 32'h0);
    send_item(OP_RECT, 0, 1, 64, 64, 32'h0);
    send_item(OP_SPARE, 127, 127, 127, 127, 32'hffff_ffff);
    send_item(OP_CLEAR, 0, 0, 0, 0, 32'h0);
    send_item(OP_RECT, 1, 1, 64, 64, 32'h0);
    send_item(OP_ADD, 64, 64, 0, 0, 32'd5);
    send_item(OP_RECT, 64, 1, 64, 64, 32'h0);

    for (p = 0; p < NUM_PHASES; p++) begin
      // bounds change with data still stored; the tree is not rebuilt
      drain_results();
      if (p >= 7) begin
        write_reg(CFG_ROWS, CfgDataW'($urandom_range(1, 64)));
        write_reg(CFG_COLS, CfgDataW'($urandom_range(1, 64)));
      end else begin
        write_reg(CFG_ROWS, phase_rows[p]);
        write_reg(CFG_COLS, phase_cols[p]);
      end
      if (p == 4) begin
        write_reg(CFG_SPARE, 7'h7f);
        write_reg(CFG_SPARE_HI, 7'h00);
      end
      for (k = 0; k < PHASE_ITEMS; k++) begin
        calm = (p % 2 == 1) && (k < 30);
        random_item();
      end
      calm = 1'b0;
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #16000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
